// ----- rtl/cursor_sequence_buffer_macros.svh -----
// Assertion macros shared by the cursor sequence buffer RTL.
// Needs clk_i in the scope of each use, and rst_ni for CSB_ASSERT.
`ifndef CURSOR_SEQUENCE_BUFFER_MACROS_SVH
`define CURSOR_SEQUENCE_BUFFER_MACROS_SVH

`ifndef ASSERT_OFF
// Check under reset gating.
`define CSB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check at every edge, reset included.
`define CSB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CSB_ASSERT(name, prop, msg)
`define CSB_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- rtl/csb_pkg.sv -----
// Shared types and constants of the cursor sequence buffer.
// No dependencies.
package csb_pkg;

  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    FN_START        = 4'd0,
    FN_END          = 4'd1,
    FN_LAST         = 4'd2,
    FN_ADVANCE      = 4'd3,
    FN_RETREAT      = 4'd4,
    FN_INSERT       = 4'd5,
    FN_INSERT_FRONT = 4'd6,
    FN_ATTACH       = 4'd7,
    FN_APPEND       = 4'd8,
    FN_REMOVE       = 4'd9,
    FN_REMOVE_FRONT = 4'd10,
    FN_READ_CURRENT = 4'd11,
    FN_READ_INDEX   = 4'd12
  } func_e;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_FULL       = 2'd1,
    ERR_NO_CURRENT = 2'd2,
    ERR_RANGE      = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_BELOW = 2'd2,
    CELL_FROM_ABOVE = 2'd3
  } cell_cmd_e;

  // Shift request from the controller to the row of cells.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] at;
  } shift_t;

  // Status of one request, plus where to read its data word.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] cursor;
    logic [CNT_W-1:0] count;
    logic             has_cur;
    err_e             err;
  } res_t;

endpackage

// ----- rtl/cursor_sequence_buffer.sv -----
// Top level of the cursor sequence buffer: row of cells, controller, output stages.
// Depends on csb_pkg, csb_cell, csb_ctrl.
//
// The block keeps an ordered list of up to DEPTH words and a cursor, one
// request per accepted input item and one result per request. Each request
// takes effect at its accept edge: the row of cells shifts the words from the
// affected place one place up (insert, insert at front, attach, append) or down
// (remove, remove at front) in parallel, so a new request may follow in every
// cycle and the sustained rate is one request per clock while results are taken.
// A result is offered once it reaches the output register: the accept edge
// updates the cells and captures the status in the pending stage, and a later
// edge, when the output register is free or being taken, reads the addressed
// cell into it. A pending stage and an output register sit between the channels:
// while a result waits in the output register one more request is taken into
// the pending stage, and after that the input stalls until the waiting result
// is taken. No clearing pass after reset; words are read only once written.
module cursor_sequence_buffer import csb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  func_i,
  input  logic [31:0] value_i,
  input  logic [4:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_value_o,
  output logic [5:0]  cursor_o,
  output logic [5:0]  count_o,
  output logic        has_current_o,
  output logic [1:0]  error_o
);

  logic                  accept;
  shift_t                shift;
  res_t                  res;
  logic [DATA_WIDTH-1:0] load_word;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  // Pending stage: status of the last request, cells already updated.
  logic                  pend_valid_q;
  res_t                  pend_q;
  logic                  pend_move;

  // Output register.
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [31:0]           out_value_q;
  logic [5:0]            out_cursor_q, out_count_q;
  logic                  out_has_q;
  logic [1:0]            out_err_q;

  // Advance pending into output when the output is free or being taken.
  assign pend_move  = pend_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_valid_q || pend_move;
  assign accept     = in_valid_i && in_ready_o;
  assign load_word  = DATA_WIDTH'(value_i);

  csb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (func_i),
    .position_i (position_i),
    .shift_o    (shift),
    .res_o      (res)
  );

  // Row of cells: each takes the new word, its lower or upper neighbor, or holds.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cell_cmd_e             cmd;
    logic [DATA_WIDTH-1:0] below, above;

    always_comb begin
      cmd = CELL_HOLD;
      if (accept) begin
        priority if (shift.ins && IDX_W'(g) == shift.at)  cmd = CELL_LOAD;
        else if (shift.ins && IDX_W'(g) > shift.at)       cmd = CELL_FROM_BELOW;
        else if (shift.rem && IDX_W'(g) >= shift.at)      cmd = CELL_FROM_ABOVE;
        else                                               cmd = CELL_HOLD;
      end
    end

    if (g == 0) begin : g_first
      assign below = load_word;
    end else begin : g_mid_lo
      assign below = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign above = cell_data[g];
    end else begin : g_mid_hi
      assign above = cell_data[g+1];
    end

    csb_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .load_i  (load_word),
      .below_i (below),
      .above_i (above),
      .data_o  (cell_data[g])
    );
  end

  // Read the addressed word from the cells once the shift has landed.
  assign rd_word = pend_q.rd_en ? cell_data[pend_q.rd_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) pend_valid_q <= 1'b1;
      else if (pend_move) pend_valid_q <= 1'b0;
      if (pend_move) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (accept) pend_q <= res;
    if (pend_move) begin
      out_value_q  <= 32'(rd_word);
      out_cursor_q <= 6'(pend_q.cursor);
      out_count_q  <= 6'(pend_q.count);
      out_has_q    <= pend_q.has_cur;
      out_err_q    <= pend_q.err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_value_q;
  assign cursor_o      = out_cursor_q;
  assign count_o       = out_count_q;
  assign has_current_o = out_has_q;
  assign error_o       = out_err_q;

endmodule

// ----- rtl/csb_cell.sv -----
// One storage cell of the cursor sequence buffer row.
// Depends on csb_pkg.
module csb_cell import csb_pkg::*; (
  input  logic                  clk_i,
  input  cell_cmd_e             cmd_i,
  input  logic [DATA_WIDTH-1:0] load_i,
  input  logic [DATA_WIDTH-1:0] below_i,
  input  logic [DATA_WIDTH-1:0] above_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    unique case (cmd_i)
      CELL_LOAD:       data_d = load_i;
      CELL_FROM_BELOW: data_d = below_i;
      CELL_FROM_ABOVE: data_d = above_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- rtl/csb_ctrl.sv -----
// Cursor and count bookkeeping of the cursor sequence buffer.
// Depends on csb_pkg and cursor_sequence_buffer_macros.svh.
`include "cursor_sequence_buffer_macros.svh"

module csb_ctrl import csb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [3:0] func_i,
  input  logic [4:0] position_i,
  output shift_t     shift_o,
  output res_t       res_o
);

  logic [CNT_W-1:0] cursor_q, cursor_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             has_cur, full, pos_ok;
  err_e             err;
  logic             rd_op, rd_en;
  logic [IDX_W-1:0] rd_idx;

  assign has_cur = cursor_q < count_q;
  assign full    = count_q == CNT_W'(DEPTH);
  assign pos_ok  = int'(position_i) < int'(count_q);

  always_comb begin
    cursor_d      = cursor_q;
    count_d       = count_q;
    err           = ERR_OK;
    shift_o.ins   = 1'b0;
    shift_o.rem   = 1'b0;
    shift_o.at    = '0;
    rd_op         = 1'b0;
    rd_en         = 1'b0;
    rd_idx        = '0;
    unique case (func_i)
      FN_START: cursor_d = '0;
      FN_END: begin
        if (count_q == '0) err = ERR_NO_CURRENT;
        else cursor_d = count_q - CNT_W'(1);
      end
      FN_LAST: cursor_d = CNT_W'(DEPTH - 1);
      FN_ADVANCE: begin
        if (!has_cur) err = ERR_NO_CURRENT;
        else cursor_d = cursor_q + CNT_W'(1);
      end
      FN_RETREAT: begin
        if (cursor_q != '0) cursor_d = cursor_q - CNT_W'(1);
      end
      FN_INSERT, FN_INSERT_FRONT, FN_ATTACH, FN_APPEND: begin
        if (full) begin
          err = ERR_FULL;
        end else begin
          priority case (func_i)
            FN_INSERT:       cursor_d = has_cur ? cursor_q : '0;
            FN_INSERT_FRONT: cursor_d = '0;
            FN_ATTACH:       cursor_d = has_cur ? cursor_q + CNT_W'(1) : count_q;
            default:         cursor_d = count_q;
          endcase
          count_d     = count_q + CNT_W'(1);
          shift_o.ins = 1'b1;
          shift_o.at  = cursor_d[IDX_W-1:0];
        end
      end
      FN_REMOVE: begin
        if (!has_cur) begin
          err = ERR_NO_CURRENT;
        end else begin
          count_d     = count_q - CNT_W'(1);
          shift_o.rem = 1'b1;
          shift_o.at  = cursor_q[IDX_W-1:0];
        end
      end
      FN_REMOVE_FRONT: begin
        if (count_q == '0) begin
          err = ERR_NO_CURRENT;
        end else begin
          cursor_d    = '0;
          count_d     = count_q - CNT_W'(1);
          shift_o.rem = 1'b1;
        end
      end
      FN_READ_CURRENT: begin
        rd_op  = 1'b1;
        rd_en  = has_cur;
        rd_idx = cursor_q[IDX_W-1:0];
        if (!has_cur) err = ERR_NO_CURRENT;
      end
      FN_READ_INDEX: begin
        rd_op  = 1'b1;
        rd_en  = pos_ok;
        rd_idx = IDX_W'(position_i);
        if (!pos_ok) err = ERR_RANGE;
      end
      default: ;
    endcase
    // Other requests report the current entry after the update.
    if (!rd_op) begin
      rd_en  = cursor_d < count_d;
      rd_idx = cursor_d[IDX_W-1:0];
    end
  end

  assign res_o.rd_en   = rd_en;
  assign res_o.rd_idx  = rd_idx;
  assign res_o.cursor  = cursor_d;
  assign res_o.count   = count_d;
  assign res_o.has_cur = cursor_d < count_d;
  assign res_o.err     = err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      count_q  <= '0;
    end else if (accept_i) begin
      cursor_q <= cursor_d;
      count_q  <= count_d;
    end
  end

  `CSB_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "count above depth")
  `CSB_ASSERT(a_fail_no_change, accept_i && err != ERR_OK |=> $stable(count_q) && $stable(cursor_q), "failed request changed state")
  `CSB_ASSERT(a_idle_hold, !accept_i |=> $stable(count_q) && $stable(cursor_q), "state moved without a request")
  `CSB_ASSERT(a_shift_excl, !(shift_o.ins && shift_o.rem), "insert and remove at once")

endmodule

// ----- dv/csb_tb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard of the cursor sequence buffer testbench: list shadow and result check.
// Depends on csb_pkg for the list depth, the operation codes and the error codes.
package csb_tb_pkg;
  import csb_pkg::*;

  typedef struct {
    logic [31:0] read_value;
    logic [5:0]  cursor;
    logic [5:0]  count;
    logic        has_current;
    err_e        error;
  } list_status_t;

  class csb_scoreboard;
    logic [31:0]  words [DEPTH];
    int unsigned  held;
    int unsigned  cursor;
    list_status_t expected_status [$];
    int unsigned  failures;
    int unsigned  results_seen;

    function new();
      held         = 0;
      cursor       = 0;
      failures     = 0;
      results_seen = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function bit has_cur();
      return cursor < held;
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction

    // Open a gap at slot at and store w there.
    function void put_at(int unsigned at, logic [31:0] w);
      for (int unsigned i = held; i > at; i--) words[i] = words[i - 1];
      words[at] = w;
      held++;
    endfunction

    // Close the gap at slot at.
    function void drop_at(int unsigned at);
      for (int unsigned i = at; i + 1 < held; i++) words[i] = words[i + 1];
      held--;
    endfunction

    // Advance the shadow list by one accepted request and queue its status.
    function void note_request(logic [3:0] f, logic [31:0] v, logic [4:0] p);
      list_status_t s;
      err_e         err;
      logic [31:0]  rd;
      bit           reading;
      bit           full;
      err     = ERR_OK;
      rd      = '0;
      reading = 1'b0;
      full    = (held >= DEPTH);
      case (f)
        FN_START: cursor = 0;
        FN_END: begin
          if (held == 0) err = ERR_NO_CURRENT;
          else cursor = held - 1;
        end
        FN_LAST: cursor = DEPTH - 1;
        FN_ADVANCE: begin
          if (!has_cur()) err = ERR_NO_CURRENT;
          else cursor++;
        end
        FN_RETREAT: begin
          if (cursor > 0) cursor--;
        end
        FN_INSERT: begin
          if (full) err = ERR_FULL;
          else begin
            if (!has_cur()) cursor = 0;
            put_at(cursor, v);
          end
        end
        FN_INSERT_FRONT: begin
          if (full) err = ERR_FULL;
          else begin
            cursor = 0;
            put_at(0, v);
          end
        end
        FN_ATTACH: begin
          if (full) err = ERR_FULL;
          else begin
            if (has_cur()) cursor++;
            else cursor = held;
            put_at(cursor, v);
          end
        end
        FN_APPEND: begin
          if (full) err = ERR_FULL;
          else begin
            cursor = held;
            put_at(cursor, v);
          end
        end
        FN_REMOVE: begin
          if (!has_cur()) err = ERR_NO_CURRENT;
          else drop_at(cursor);
        end
        FN_REMOVE_FRONT: begin
          if (held == 0) err = ERR_NO_CURRENT;
          else begin
            cursor = 0;
            drop_at(0);
          end
        end
        FN_READ_CURRENT: begin
          reading = 1'b1;
          if (has_cur()) rd = words[cursor];
          else err = ERR_NO_CURRENT;
        end
        FN_READ_INDEX: begin
          reading = 1'b1;
          if (p < held) rd = words[p];
          else err = ERR_RANGE;
        end
        default: ;
      endcase
      if (!reading && has_cur()) rd = words[cursor];
      s.read_value  = rd;
      s.cursor      = 6'(cursor);
      s.count       = 6'(held);
      s.has_current = has_cur();
      s.error       = err;
      expected_status.push_back(s);
    endfunction

    task report(string msg);
      // Keep the log short on a badly broken build; count every mismatch.
      if (failures < 100) $display("mismatch at result %0d: %s", results_seen, msg);
      failures++;
    endtask

    task check_result(logic [31:0] rv, logic [5:0] cur, logic [5:0] cnt, logic hc,
                      logic [1:0] er);
      list_status_t s;
      if (expected_status.size() == 0) begin
        report($sformatf("result with no request pending (value %h cursor %0d count %0d)",
                         rv, cur, cnt));
      end else begin
        s = expected_status.pop_front();
        if (rv !== s.read_value)
          report($sformatf("read_value %h, want %h", rv, s.read_value));
        if (cur !== s.cursor)
          report($sformatf("cursor %0d, want %0d", cur, s.cursor));
        if (cnt !== s.count)
          report($sformatf("count %0d, want %0d", cnt, s.count));
        if (hc !== s.has_current)
          report($sformatf("has_current %b, want %b", hc, s.has_current));
        if (er !== s.error)
          report($sformatf("error %0d, want %0d", er, s.error));
      end
      results_seen++;
    endtask
  endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the cursor sequence buffer testbench: clock, reset, request and result drivers.
// Depends on csb_pkg, csb_tb_pkg and the cursor_sequence_buffer RTL.
module tb_top;
  import csb_pkg::*;
  import csb_tb_pkg::*;

  // Codes 13 to 15 select no operation; the block must leave the list alone.
  localparam logic [3:0] FN_UNUSED_LO = 4'd13;
  localparam logic [3:0] FN_UNUSED_HI = 4'd15;

  localparam int unsigned RANDOM_ITEMS    = 1800;
  localparam int unsigned MIX_SPAN        = 80;   // requests per random mix
  localparam int unsigned CALM_SPAN       = 64;   // items per idling decision
  localparam int unsigned PRESSURE_AT     = 400;  // result index of the long hold-off
  localparam int unsigned PRESSURE_CYCLES = 150;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned TIMEOUT_NS      = 2_000_000;

  // Mix of operations for a stretch of random requests: grow the list toward
  // full, shrink it toward empty, or keep it wandering.
  typedef enum {MIX_GROW, MIX_SHRINK, MIX_ANY} mix_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [3:0]  func_i;
  logic [31:0] value_i;
  logic [4:0]  position_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] read_value_o;
  logic [5:0]  cursor_o;
  logic [5:0]  count_o;
  logic        has_current_o;
  logic [1:0]  error_o;

  csb_scoreboard sb;

  int unsigned sent_count = 0;
  bit          send_calm  = 1'b0;

  cursor_sequence_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_value_o  (read_value_o),
    .cursor_o      (cursor_o),
    .count_o       (count_o),
    .has_current_o (has_current_o),
    .error_o       (error_o)
  );

  always #5 clk_i = ~clk_i;

  // Offer one request and hold it until the block takes it. All inputs move
  // by nonblocking assignment at the rising edge and outputs are sampled
  // right after that edge, so both sides see the values from before it.
  task automatic send_request(input logic [3:0] f, input logic [31:0] v,
                              input logic [4:0] p);
    int unsigned gap;
    // Every so often switch between random gaps and back-to-back requests.
    if (sent_count % CALM_SPAN == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    value_i    <= v;
    position_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    // Accepted at this edge: advance the shadow list now, results come in order.
    sb.note_request(f, v, p);
    sent_count++;
  endtask

  // Request source: directed corner cases, then random mixes.
  initial begin
    mix_e        mix;
    int unsigned grow_pct;
    int unsigned shrink_pct;
    int unsigned r;
    logic [3:0]  f;
    logic [31:0] v;
    logic [4:0]  p;

    in_valid_i  <= 1'b0;
    func_i      <= '0;
    value_i     <= '0;
    position_i  <= '0;
    out_ready_i <= 1'b0;
    rst_ni      <= 1'b0;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: every operation that needs an entry must fail and change nothing.
    send_request(FN_READ_CURRENT, 32'h0, 5'd0);
    send_request(FN_END,          32'h0, 5'd0);
    send_request(FN_ADVANCE,      32'h0, 5'd0);
    send_request(FN_REMOVE,       32'h0, 5'd0);
    send_request(FN_REMOVE_FRONT, 32'h0, 5'd0);
    send_request(FN_READ_INDEX,   32'h0, 5'd0);
    send_request(FN_RETREAT,      32'h0, 5'd0);
    // Park the cursor past the end, then insert with no current entry.
    send_request(FN_LAST,         32'h0, 5'd31);
    send_request(FN_INSERT,       32'h0000_0000, 5'd0);
    send_request(FN_INSERT_FRONT, 32'hFFFF_FFFF, 5'd0);
    send_request(FN_ATTACH,       32'h1234_5678, 5'd0);
    send_request(FN_APPEND,       32'hA5A5_A5A5, 5'd0);
    send_request(FN_START,        32'h0, 5'd0);
    send_request(FN_ADVANCE,      32'h0, 5'd0);
    send_request(FN_READ_CURRENT, 32'h0, 5'd0);
    send_request(FN_READ_INDEX,   32'h0, 5'd3);
    send_request(FN_READ_INDEX,   32'h0, 5'd31);
    // Remove the last entry, which leaves no current entry; attach goes to the back.
    send_request(FN_END,          32'h0, 5'd0);
    send_request(FN_REMOVE,       32'h0, 5'd0);
    send_request(FN_ATTACH,       32'h5A5A_5A5A, 5'd0);
    send_request(FN_RETREAT,      32'h0, 5'd0);
    send_request(FN_REMOVE_FRONT, 32'h0, 5'd0);
    send_request(FN_UNUSED_LO,    32'hDEAD_BEEF, 5'd7);
    send_request(FN_UNUSED_HI,    32'h0, 5'd0);

    mix = MIX_GROW;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % MIX_SPAN == 0) mix = mix_e'($urandom_range(0, 2));
      case (mix)
        MIX_GROW:   begin grow_pct = 70; shrink_pct = 10; end
        MIX_SHRINK: begin grow_pct = 10; shrink_pct = 60; end
        default:    begin grow_pct = 30; shrink_pct = 25; end
      endcase
      r = $urandom_range(0, 99);
      if (r < grow_pct)
        f = 4'($urandom_range(FN_INSERT, FN_APPEND));
      else if (r < grow_pct + shrink_pct)
        f = 4'($urandom_range(FN_REMOVE, FN_REMOVE_FRONT));
      else if (r < grow_pct + shrink_pct + 12)
        f = 4'($urandom_range(FN_START, FN_RETREAT));
      else if (r < 97)
        f = 4'($urandom_range(FN_READ_CURRENT, FN_READ_INDEX));
      else
        f = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      // Bias data toward the extremes now and then.
      r = $urandom_range(0, 9);
      if (r == 0)      v = 32'h0000_0000;
      else if (r == 1) v = 32'hFFFF_FFFF;
      else             v = $urandom;
      // Mostly aim read_index at a stored entry; otherwise anywhere.
      if (sb.held > 0 && $urandom_range(0, 3) != 0) p = 5'($urandom_range(0, sb.held - 1));
      else p = 5'($urandom);
      send_request(f, v, p);
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every pending result, then watch for stray ones.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result sink: random back-pressure, calm stretches, and one long hold-off
  // that fills the block and stalls its input while requests keep coming.
  initial begin
    int unsigned hold;
    int unsigned seen;
    bit          calm;
    seen = 0;
    calm = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (seen % CALM_SPAN == 0) calm = ($urandom_range(0, 3) == 0);
      if (seen == PRESSURE_AT) hold = PRESSURE_CYCLES;
      else hold = calm ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(read_value_o, cursor_o, count_o, has_current_o, error_o);
      seen++;
    end
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
